FILE: hdl/mhpq_pkg.sv
package mhpq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned PRIO_W   = 16;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_REMOVED  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    ACTION_INSERT = 1'b0,
    ACTION_REMOVE = 1'b1
  } action_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

FILE: hdl/mhpq_if.sv
interface mhpq_in_if import mhpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [ID_W-1:0]   job_id;
  logic [PRIO_W-1:0] job_priority;

  modport source (output valid, output action, output job_id, output job_priority,
                  input ready);
  modport sink (input valid, input action, input job_id, input job_priority,
                output ready);
endinterface

interface mhpq_out_if import mhpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   out_job_id;
  logic [PRIO_W-1:0] out_priority;
  logic [CNT_W-1:0]  job_count;

  modport source (output valid, output status, output out_job_id, output out_priority,
                  output job_count, input ready);
  modport sink (input valid, input status, input out_job_id, input out_priority,
                input job_count, output ready);
endinterface

FILE: hdl/max_heap_priority_queue.sv
// Binary max-heap of 64 jobs held in a memory with one write and two read ports.
// A refused insert or an empty pop goes straight to the result state; an insert climbs from
// the new last slot toward the root and a pop sifts the last entry down from the root.
// Each level costs one registered memory read and one compare-and-write step; the
// input is ready only when idle.
// Reset empties the heap and clears the sequencer; heap contents are not cleared.
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mhpq_in_if.sink       in_i,
  mhpq_out_if.source    out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UP    = 3'd1;
  localparam logic [2:0] S_UPCMP = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_DN    = 3'd4;
  localparam logic [2:0] S_DNCMP = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  entry_t            cur_q, cur_d;
  status_e           status_q, status_d;
  entry_t            res_q, res_d;

  entry_t            heap_mem [CAPACITY];
  entry_t            rd_a_q, rd_b_q;
  logic [IDX_W-1:0]  rd_a_addr, rd_b_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic [IDX_W-1:0]  parent_idx;
  logic [CNT_W-1:0]  left_idx, right_idx;
  logic              left_ok, right_ok, take_left, take_right;
  logic [PRIO_W-1:0] best_prio;

  assign parent_idx = (idx_q - IDX_W'(1)) >> 1;
  assign left_idx   = {idx_q, 1'b1};
  assign right_idx  = {idx_q, 1'b0} + CNT_W'(2);
  assign left_ok    = left_idx < cnt_q;
  assign right_ok   = right_idx < cnt_q;
  assign take_left  = left_ok && (rd_a_q.prio > cur_q.prio);
  assign best_prio  = take_left ? rd_a_q.prio : cur_q.prio;
  assign take_right = right_ok && (rd_b_q.prio > best_prio);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    status_d  = status_q;
    res_d     = res_q;
    rd_a_addr = left_idx[IDX_W-1:0];
    rd_b_addr = right_idx[IDX_W-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_data   = cur_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          res_d = '0;
          if (in_i.action == ACTION_INSERT) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = S_OUT;
            end else begin
              status_d = STATUS_INSERTED;
              cur_d    = '{prio: in_i.job_priority, id: in_i.job_id};
              idx_d    = cnt_q[IDX_W-1:0];
              cnt_d    = cnt_q + CNT_W'(1);
              state_d  = S_UP;
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = S_OUT;
            end else begin
              status_d  = STATUS_REMOVED;
              rd_a_addr = '0;
              rd_b_addr = IDX_W'(cnt_q - CNT_W'(1));
              cnt_d     = cnt_q - CNT_W'(1);
              state_d   = S_POP;
            end
          end
        end
      end
      S_UP: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_OUT;
        end else begin
          rd_a_addr = parent_idx;
          state_d   = S_UPCMP;
        end
      end
      S_UPCMP: begin
        wr_en = 1'b1;
        if (rd_a_q.prio < cur_q.prio) begin
          wr_data = rd_a_q;
          idx_d   = parent_idx;
          state_d = S_UP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_POP: begin
        res_d   = rd_a_q;
        cur_d   = rd_b_q;
        idx_d   = '0;
        state_d = S_DN;
      end
      S_DN: begin
        if (!left_ok) begin
          wr_en   = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_DNCMP;
        end
      end
      S_DNCMP: begin
        wr_en = 1'b1;
        if (take_right) begin
          wr_data = rd_b_q;
          idx_d   = right_idx[IDX_W-1:0];
          state_d = S_DN;
        end else if (take_left) begin
          wr_data = rd_a_q;
          idx_d   = left_idx[IDX_W-1:0];
          state_d = S_DN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cur_q    <= cur_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.status       = status_q;
  assign out_o.out_job_id   = res_q.id;
  assign out_o.out_priority = res_q.prio;
  assign out_o.job_count    = cnt_q;

endmodule

FILE: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } job_op_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mhpq_in_if  in_if ();
  mhpq_out_if out_if ();

  max_heap_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  job_op_t     queued_ops[$];
  reply_t      predicted_replies[$];
  entry_t      heap_mem [CAPACITY];
  int unsigned heap_cnt = 0;

  logic op_taken = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   cycles = 0;
  bit   failed = 1'b0;

  always #1 clk_i = ~clk_i;

  function automatic reply_t heap_apply(job_op_t op);
    reply_t      r;
    int unsigned idx;
    int unsigned par;
    int unsigned lc;
    int unsigned rc;
    int unsigned best;
    entry_t      tmp;
    r = '0;
    if (op.action == ACTION_INSERT) begin
      if (heap_cnt >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        idx = heap_cnt;
        heap_mem[idx].prio = op.prio;
        heap_mem[idx].id = op.id;
        heap_cnt++;
        while (idx > 0) begin
          par = (idx - 1) / 2;
          if (heap_mem[par].prio >= heap_mem[idx].prio) break;
          tmp = heap_mem[par];
          heap_mem[par] = heap_mem[idx];
          heap_mem[idx] = tmp;
          idx = par;
        end
        r.status = STATUS_INSERTED;
      end
    end else if (heap_cnt == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.id = heap_mem[0].id;
      r.prio = heap_mem[0].prio;
      heap_cnt--;
      heap_mem[0] = heap_mem[heap_cnt];
      idx = 0;
      forever begin
        lc = 2 * idx + 1;
        rc = lc + 1;
        best = idx;
        if (lc < heap_cnt && heap_mem[lc].prio > heap_mem[best].prio) best = lc;
        if (rc < heap_cnt && heap_mem[rc].prio > heap_mem[best].prio) best = rc;
        if (best == idx) break;
        tmp = heap_mem[idx];
        heap_mem[idx] = heap_mem[best];
        heap_mem[best] = tmp;
        idx = best;
      end
      r.status = STATUS_REMOVED;
    end
    r.count = CNT_W'(heap_cnt);
    return r;
  endfunction

  always @(posedge clk_i) begin
    reply_t got;
    reply_t want;
    op_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status = out_if.status;
      got.id = out_if.out_job_id;
      got.prio = out_if.out_priority;
      got.count = out_if.job_count;
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected result status %0d id %h prio %h count %0d", $time,
                 got.status, got.id, got.prio, got.count);
        failed = 1'b1;
      end else begin
        want = predicted_replies.pop_front();
        if (got !== want) begin
          $display("%0t: expected status %0d id %h prio %h count %0d,",
                   $time, want.status, want.id, want.prio, want.count,
                   " got status %0d id %h prio %h count %0d",
                   got.status, got.id, got.prio, got.count);
          failed = 1'b1;
        end
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      predicted_replies.push_back(heap_apply({in_if.action, in_if.job_id, in_if.job_priority}));
    end
  end

  always @(negedge clk_i) begin
    job_op_t op;
    if (!in_if.valid || op_taken) begin
      if (queued_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        op = queued_ops.pop_front();
        in_if.valid <= 1'b1;
        in_if.action <= op.action;
        in_if.job_id <= op.id;
        in_if.job_priority <= op.prio;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_op(action_e act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
    job_op_t op;
    op.action = act;
    op.id = id;
    op.prio = prio;
    queued_ops.push_back(op);
  endtask

  // Bursts lean toward filling or draining the heap so that both the full and
  // the empty cases come up often, with unbiased noise mixed in.
  task automatic queue_random(int n);
    int      left;
    int      burst;
    int      ins_pct;
    int      style;
    job_op_t op;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(8, 120);
      if (burst > left) burst = left;
      case ($urandom_range(0, 3))
        0: ins_pct = 90;
        1: ins_pct = 10;
        2: ins_pct = 60;
        default: ins_pct = 50;
      endcase
      style = $urandom_range(0, 2);
      repeat (burst) begin
        op.action = ($urandom_range(99) < ins_pct) ? ACTION_INSERT : ACTION_REMOVE;
        op.id = ID_W'($urandom);
        case (style)
          0: op.prio = PRIO_W'($urandom);
          1: op.prio = PRIO_W'($urandom_range(0, 7));
          default: op.prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 1))
                                                  : ~PRIO_W'($urandom_range(0, 1));
        endcase
        queued_ops.push_back(op);
      end
      left -= burst;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (queued_ops.size() != 0 || in_if.valid || predicted_replies.size() != 0);
  endtask

  initial begin
    int phase;
    int chunk;
    in_if.valid = 1'b0;
    in_if.action = ACTION_INSERT;
    in_if.job_id = '0;
    in_if.job_priority = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    for (phase = 0; phase < 3; phase++) begin
      @(posedge clk_i);
      tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 53 : 0;
      rx_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 35 : 0;
      if (phase == 0) begin
        push_op(ACTION_REMOVE, 16'hFFFF, 16'hFFFF);
        push_op(ACTION_INSERT, 16'h0000, 16'h0000);
        push_op(ACTION_INSERT, 16'hFFFF, 16'hFFFF);
        push_op(ACTION_INSERT, 16'h1234, 16'hFFFF);
        push_op(ACTION_INSERT, 16'hABCD, 16'h0000);
        push_op(ACTION_INSERT, 16'h5555, 16'h8000);
        push_op(ACTION_INSERT, 16'hAAAA, 16'h8000);
        repeat (3) push_op(ACTION_REMOVE, 16'h0000, 16'h0000);
        repeat (4) push_op(ACTION_REMOVE, 16'hFFFF, 16'hFFFF);
        push_op(ACTION_INSERT, 16'h0001, 16'h000A);
        push_op(ACTION_INSERT, 16'h0002, 16'h0003);
        push_op(ACTION_INSERT, 16'h0003, 16'h0003);
        push_op(ACTION_INSERT, 16'h0004, 16'h0001);
        repeat (4) push_op(ACTION_REMOVE, 16'h5A5A, 16'hA5A5);
        wait_drained();
      end
      for (chunk = 0; chunk < 4; chunk++) begin
        queue_random(160);
        if (phase == 2 && chunk == 1) begin
          @(posedge clk_i);
          hold_req = 1'b1;
          @(posedge clk_i);
          hold_req = 1'b0;
        end
        wait_drained();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mhpq_pkg.sv
hdl/mhpq_if.sv
hdl/max_heap_priority_queue.sv
test/testbench.sv
